### hw/rtl/bfau_pkg.sv
// Shared types and constants for the bfloat16 arithmetic unit.
// Holds the opcodes, pipeline stage records and the leading-zero count.
// No dependencies.
package bfau_pkg;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_MUL  = 3'd1,
    OP_F2I  = 3'd2,
    OP_FRAC = 3'd3,
    OP_AEXP = 3'd4
  } op_t;

  localparam logic [15:0] CANON_NAN = 16'h7FC0;
  localparam logic [14:0] INF_MAG   = 15'h7F80;
  localparam int          ALN_W     = 35;
  localparam int          SUM_W     = 36;

  typedef struct packed {
    logic is_arith;
    logic is_mul;
    logic nan;
    logic inf;
    logic mzero;
    logic sgn;
    logic zsgn;
  } flg_t;

  typedef struct packed {
    flg_t              f;
    logic              sub;
    logic [7:0]        m_big;
    logic [7:0]        m_b;
    logic [ALN_W-1:0]  m_al;
    logic signed [10:0] k;
    logic [15:0]       fb;
    logic [16:0]       iv;
  } s1_t;

  typedef struct packed {
    flg_t              f;
    logic [SUM_W-1:0]  s;
    logic signed [10:0] k;
    logic [15:0]       fb;
    logic [16:0]       iv;
  } s2_t;

  typedef struct packed {
    flg_t              f;
    logic [SUM_W-1:0]  s;
    logic signed [10:0] k;
    logic [5:0]        lz;
    logic              zero;
    logic [15:0]       fb;
    logic [16:0]       iv;
  } s3_t;

  typedef struct packed {
    flg_t              f;
    logic [SUM_W-1:0]  n;
    logic [7:0]        e;
    logic              ovf;
    logic              zero;
    logic [15:0]       fb;
    logic [16:0]       iv;
  } s4_t;

  function automatic logic [5:0] lzc36(input logic [SUM_W-1:0] v);
    logic [5:0] cnt;
    logic       found;
    cnt   = 6'(SUM_W);
    found = 1'b0;
    for (int i = SUM_W - 1; i >= 0; i--) begin
      if (!found && v[i]) begin
        cnt   = 6'(SUM_W - 1 - i);
        found = 1'b1;
      end
    end
    return cnt;
  endfunction

endpackage

### hw/rtl/bf16_arith_unit_top.sv
// Top level of the bfloat16 arithmetic unit: a five-stage pipeline.
// Depends on bfau_pkg for opcodes, stage records and the leading-zero count.
//
//   channel  | ports                                      | handshake
//   input    | in_op, in_operand_a, in_operand_b          | start high, busy low
//   result   | out_float_bits, out_int_value              | out_valid strobe
//
// Every accepted request gives exactly one result.
// A new request may be accepted in every cycle; busy is high only while
// reset is held and in the cycle that follows it. Stages: align, add or multiply, leading-zero
// count, normalize, round. Reset clears all valid bits of the pipeline.
// The receiver cannot stall, so nothing ever holds the pipeline.
module bf16_arith_unit_top
  import bfau_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_op,
  input  logic [15:0]        in_operand_a,
  input  logic [15:0]        in_operand_b,
  output logic               out_valid,
  output logic [15:0]        out_float_bits,
  output logic signed [16:0] out_int_value
);

  logic busy_r;
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  s4_t  s4_r, s4_nxt;
  logic [15:0] fb_r, fb_nxt;
  logic [16:0] iv_r, iv_nxt;
  logic        acc;

  assign acc  = start && !busy_r;
  assign busy = busy_r;

  // Stage 1: decode, special values, operand alignment and integer ops.
  always_comb begin
    logic       sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, a_big;
    logic [7:0] ea, eb, ea_ef, eb_ef, ma, mb, m_s, d, sh, sh2, m;
    logic [ALN_W-1:0] small35, lost;
    logic [29:0] t23;
    logic [22:0] t16;
    logic [15:0] ival;
    logic [7:0]  fr;
    sa = in_operand_a[15];
    sb = in_operand_b[15];
    ea = in_operand_a[14:7];
    eb = in_operand_b[14:7];
    a_nan  = (ea == 8'hFF) && (in_operand_a[6:0] != 7'd0);
    b_nan  = (eb == 8'hFF) && (in_operand_b[6:0] != 7'd0);
    a_inf  = (ea == 8'hFF) && (in_operand_a[6:0] == 7'd0);
    b_inf  = (eb == 8'hFF) && (in_operand_b[6:0] == 7'd0);
    a_zero = in_operand_a[14:0] == 15'd0;
    b_zero = in_operand_b[14:0] == 15'd0;
    ea_ef  = (ea == 8'd0) ? 8'd1 : ea;
    eb_ef  = (eb == 8'd0) ? 8'd1 : eb;
    ma     = {(ea != 8'd0), in_operand_a[6:0]};
    mb     = {(eb != 8'd0), in_operand_b[6:0]};
    a_big  = in_operand_a[14:0] >= in_operand_b[14:0];
    m_s     = 8'd0;
    d       = 8'd0;
    small35 = '0;
    lost    = '0;

    s1_nxt          = '0;
    s1_nxt.f.is_mul = (in_op == OP_MUL);
    s1_nxt.f.is_arith = (in_op == OP_ADD) || (in_op == OP_MUL);
    s1_nxt.sub      = sa ^ sb;
    s1_nxt.f.zsgn   = sa & sb;

    if (in_op == OP_MUL) begin
      s1_nxt.f.nan   = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
      s1_nxt.f.inf   = !s1_nxt.f.nan && (a_inf || b_inf);
      s1_nxt.f.mzero = a_zero || b_zero;
      s1_nxt.f.sgn   = sa ^ sb;
      s1_nxt.m_big   = ma;
      s1_nxt.m_b     = mb;
      s1_nxt.k       = $signed({3'b000, ea_ef}) + $signed({3'b000, eb_ef}) - 11'sd127;
    end else begin
      s1_nxt.f.nan = a_nan || b_nan || (a_inf && b_inf && (sa != sb));
      s1_nxt.f.inf = !s1_nxt.f.nan && (a_inf || b_inf);
      s1_nxt.f.sgn = (a_inf || b_inf) ? (a_inf ? sa : sb) : (a_big ? sa : sb);
      s1_nxt.m_big = a_big ? ma : mb;
      m_s          = a_big ? mb : ma;
      d            = a_big ? (ea_ef - eb_ef) : (eb_ef - ea_ef);
      small35      = {m_s, 27'd0};
      if (d >= 8'(ALN_W)) begin
        s1_nxt.m_al = {{(ALN_W-1){1'b0}}, (m_s != 8'd0)};
      end else begin
        lost        = small35 & ~({ALN_W{1'b1}} << d[5:0]);
        s1_nxt.m_al = (small35 >> d[5:0]) | {{(ALN_W-1){1'b0}}, (lost != '0)};
      end
      s1_nxt.k = $signed({3'b000, a_big ? ea_ef : eb_ef});
    end

    m    = {1'b1, in_operand_a[6:0]};
    sh   = ea - 8'd127;
    sh2  = 8'd127 - ea;
    ival = 16'd0;
    fr   = 8'd0;
    t23  = {22'd0, m} << sh[4:0];
    t16  = {15'd0, m} << sh[3:0];
    if (ea >= 8'd127 && sh < 8'd23) begin
      ival = t23[22:7];
    end
    if (ea >= 8'd127) begin
      if (sh < 8'd16) fr = {1'b0, t16[6:0]};
    end else if (sh2 < 8'd16) begin
      fr = {1'b0, 7'(m >> sh2[3:0])};
    end
    unique case (in_op)
      OP_F2I:  s1_nxt.iv = sa ? (17'd0 - {1'b0, ival}) : {1'b0, ival};
      OP_FRAC: s1_nxt.iv = sa ? (17'd0 - {9'd0, fr}) : {9'd0, fr};
      OP_AEXP: s1_nxt.fb = {in_operand_a[15], ea + in_operand_b[7:0], in_operand_a[6:0]};
      default: ;
    endcase
  end

  // Stage 2: significand add, subtract or multiply.
  always_comb begin
    logic [SUM_W-1:0] big, sml;
    logic [15:0]      mp;
    s2_nxt.f  = s1_r.f;
    s2_nxt.k  = s1_r.k;
    s2_nxt.fb = s1_r.fb;
    s2_nxt.iv = s1_r.iv;
    big = {1'b0, s1_r.m_big, 27'd0};
    sml = {1'b0, s1_r.m_al};
    mp  = s1_r.m_big * s1_r.m_b;
    if (s1_r.f.is_mul) begin
      s2_nxt.s = {mp, 20'd0};
    end else if (s1_r.sub) begin
      s2_nxt.s = big - sml;
    end else begin
      s2_nxt.s = big + sml;
    end
  end

  // Stage 3: leading-zero count.
  always_comb begin
    s3_nxt.f    = s2_r.f;
    s3_nxt.s    = s2_r.s;
    s3_nxt.k    = s2_r.k;
    s3_nxt.fb   = s2_r.fb;
    s3_nxt.iv   = s2_r.iv;
    s3_nxt.lz   = lzc36(s2_r.s);
    s3_nxt.zero = (s2_r.s == '0) || (s2_r.f.is_mul && s2_r.f.mzero);
  end

  // Stage 4: normalize or denormalize, exponent and overflow.
  always_comb begin
    logic signed [10:0] lz_s, e_full, nk;
    logic [SUM_W-1:0]   lost;
    lz_s        = $signed({5'd0, s3_r.lz});
    e_full      = s3_r.k + 11'sd1 - lz_s;
    nk          = 11'sd0 - s3_r.k;
    s4_nxt.f    = s3_r.f;
    s4_nxt.fb   = s3_r.fb;
    s4_nxt.iv   = s3_r.iv;
    s4_nxt.zero = s3_r.zero;
    s4_nxt.e    = 8'd0;
    s4_nxt.ovf  = 1'b0;
    lost        = '0;
    if (s3_r.k >= lz_s) begin
      s4_nxt.n   = s3_r.s << s3_r.lz;
      s4_nxt.e   = e_full[7:0];
      s4_nxt.ovf = e_full >= 11'sd255;
    end else if (s3_r.k >= 11'sd0) begin
      s4_nxt.n = s3_r.s << s3_r.k[5:0];
    end else if (nk >= 11'(SUM_W)) begin
      s4_nxt.n = {{(SUM_W-1){1'b0}}, (s3_r.s != '0)};
    end else begin
      lost     = s3_r.s & ~({SUM_W{1'b1}} << nk[5:0]);
      s4_nxt.n = (s3_r.s >> nk[5:0]) | {{(SUM_W-1){1'b0}}, (lost != '0)};
    end
  end

  // Stage 5: fp32 rounding, bf16 rounding and result select.
  always_comb begin
    logic        inc32, inc16;
    logic [30:0] mag;
    logic [15:0] hi, lo, rnd;
    inc32 = s4_r.n[11] && ((s4_r.n[10:0] != 11'd0) || s4_r.n[12]);
    mag   = {s4_r.e, s4_r.n[34:12]} + {30'd0, inc32};
    hi    = {s4_r.f.sgn, mag[30:16]};
    lo    = mag[15:0];
    if (s4_r.f.is_mul) begin
      inc16 = lo[15] && (lo[14] || lo[13] || hi[0]);
    end else begin
      inc16 = (lo > 16'h8000) || ((lo == 16'h8000) && hi[0]);
    end
    rnd = inc16 ? {hi[15], hi[14:0] + 15'd1} : hi;
    iv_nxt = s4_r.iv;
    if (!s4_r.f.is_arith) begin
      fb_nxt = s4_r.fb;
    end else if (s4_r.f.nan) begin
      fb_nxt = CANON_NAN;
    end else if (s4_r.f.inf || s4_r.ovf) begin
      fb_nxt = {s4_r.f.sgn, INF_MAG};
    end else if (s4_r.zero) begin
      fb_nxt = {(s4_r.f.is_mul ? s4_r.f.sgn : s4_r.f.zsgn), 15'd0};
    end else begin
      fb_nxt = rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      v1_r        <= acc;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
    s4_r <= s4_nxt;
    fb_r <= fb_nxt;
    iv_r <= iv_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_float_bits = fb_r;
  assign out_int_value  = $signed(iv_r);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, 5))
    else $error("result strobe without a matching request");

  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_float_bits == 16'd0 || out_int_value == 17'sd0))
    else $error("both result fields nonzero");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && s4_r.f.is_arith && s4_r.zero && !s4_r.f.nan && !s4_r.f.inf)
    |=> (out_float_bits[14:0] == 15'd0))
    else $error("zero result not delivered as signed zero");

endmodule

### verif/testbench.sv
// Self-checking testbench for the bfloat16 arithmetic unit: a directed table, then random requests.
// Expected results are table rows or an exact integer model of fp32 add, multiply, bf16 rounding.
// Depends on bfau_pkg and bf16_arith_unit_top.
module testbench;
  import bfau_pkg::*;

  typedef logic [319:0] wide_t;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] a;
    logic [15:0] b;
    logic        typed;
    logic [15:0] fb;
    logic [16:0] iv;
  } row_t;

  typedef struct {
    logic [15:0] fb;
    logic [16:0] iv;
  } res_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic [2:0]         in_op = '0;
  logic [15:0]        in_operand_a = '0;
  logic [15:0]        in_operand_b = '0;
  logic               busy;
  logic               out_valid;
  logic [15:0]        out_float_bits;
  logic signed [16:0] out_int_value;

  res_t pending_results[$];
  int   errors = 0;
  int   sent = 0;
  int   checked = 0;
  int   quiet_cycles = 0;
  logic fast_mode = 1'b0;

  bf16_arith_unit_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_float_bits(out_float_bits), .out_int_value(out_int_value)
  );

  always #10 clk = ~clk;

  function automatic logic is_nan16(input logic [15:0] v);
    return (v[14:7] == 8'hFF) && (v[6:0] != 7'd0);
  endfunction

  function automatic logic is_inf16(input logic [15:0] v);
    return (v[14:7] == 8'hFF) && (v[6:0] == 7'd0);
  endfunction

  function automatic void split_bf16(input logic [15:0] v, output wide_t sig, output int ex);
    if (v[14:7] == 8'd0) begin
      sig = wide_t'(v[6:0]);
      ex  = -133;
    end else begin
      sig = wide_t'({1'b1, v[6:0]});
      ex  = int'(v[14:7]) - 134;
    end
  endfunction

  function automatic logic [31:0] round_fp32(input logic s, input wide_t m, input int ex);
    int    p;
    int    lsb;
    int    sh;
    int    bexp;
    wide_t q;
    wide_t rem;
    wide_t half;
    if (m == '0) return {s, 31'd0};
    p = 0;
    for (int i = 0; i < 320; i++) if (m[i]) p = i;
    lsb = p + ex - 23;
    if (lsb < -149) lsb = -149;
    sh = lsb - ex;
    if (sh > 0) begin
      q    = m >> sh;
      rem  = m - (q << sh);
      half = wide_t'(1) << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
    end else begin
      q = m << (-sh);
    end
    if (q[24]) begin
      q   = q >> 1;
      lsb = lsb + 1;
    end
    bexp = q[23] ? lsb + 150 : 0;
    if (bexp >= 255) return {s, 8'hFF, 23'd0};
    return {s, bexp[7:0], q[22:0]};
  endfunction

  function automatic logic [31:0] fp32_sum(input logic [15:0] a, input logic [15:0] b);
    wide_t sa, sb, ma, mb, m;
    int    xa, xb, emin;
    logic  s;
    if (is_nan16(a) || is_nan16(b)) return 32'h7FC00000;
    if (is_inf16(a)) begin
      if (is_inf16(b) && a[15] != b[15]) return 32'h7FC00000;
      return {a, 16'd0};
    end
    if (is_inf16(b)) return {b, 16'd0};
    split_bf16(a, sa, xa);
    split_bf16(b, sb, xb);
    emin = (xa < xb) ? xa : xb;
    ma = sa << (xa - emin);
    mb = sb << (xb - emin);
    if (a[15] == b[15]) begin
      m = ma + mb;
      s = a[15];
    end else if (ma > mb) begin
      m = ma - mb;
      s = a[15];
    end else if (mb > ma) begin
      m = mb - ma;
      s = b[15];
    end else begin
      m = '0;
      s = 1'b0;
    end
    return round_fp32(s, m, emin);
  endfunction

  function automatic logic [31:0] fp32_product(input logic [15:0] a, input logic [15:0] b);
    wide_t sa, sb;
    int    xa, xb;
    logic  s;
    logic  za, zb;
    s  = a[15] ^ b[15];
    za = (a[14:0] == 15'd0);
    zb = (b[14:0] == 15'd0);
    if (is_nan16(a) || is_nan16(b)) return 32'h7FC00000;
    if ((is_inf16(a) && zb) || (is_inf16(b) && za)) return 32'h7FC00000;
    if (is_inf16(a) || is_inf16(b)) return {s, 8'hFF, 23'd0};
    split_bf16(a, sa, xa);
    split_bf16(b, sb, xb);
    return round_fp32(s, sa * sb, xa + xb);
  endfunction

  function automatic logic [15:0] bf16_narrow(input logic [31:0] r, input logic mul);
    logic [15:0] hi;
    logic [15:0] lo;
    logic        up;
    hi = r[31:16];
    lo = r[15:0];
    if (r[30:23] == 8'hFF && r[22:0] != 23'd0) return CANON_NAN;
    if (mul) up = lo[15] && (lo[14:13] != 2'd0 || hi[0]);
    else     up = (lo > 16'h8000) || (lo == 16'h8000 && hi[0]);
    if (up) hi = {hi[15], hi[14:0] + 15'd1};
    return hi;
  endfunction

  function automatic logic [31:0] scaled_sig(input logic [15:0] a, input int width);
    int          e;
    int          s;
    logic [31:0] m;
    logic [31:0] mask;
    e    = int'(a[14:7]);
    m    = {24'd0, 1'b1, a[6:0]};
    mask = (32'h1 << width) - 32'h1;
    if (e >= 127) begin
      s = e - 127;
      return (s < width) ? ((m << s) & mask) : 32'd0;
    end
    s = 127 - e;
    return (s < width) ? (m >> s) : 32'd0;
  endfunction

  function automatic logic [16:0] signed_of(input logic [15:0] a, input logic [31:0] v);
    logic [16:0] w;
    w = v[16:0];
    return a[15] ? (17'd0 - w) : w;
  endfunction

  function automatic res_t alu_result(input logic [2:0] op, input logic [15:0] a,
                                      input logic [15:0] b);
    res_t r;
    r.fb = '0;
    r.iv = '0;
    case (op)
      OP_ADD:  r.fb = bf16_narrow(fp32_sum(a, b), 1'b0);
      OP_MUL:  r.fb = bf16_narrow(fp32_product(a, b), 1'b1);
      OP_F2I:  r.iv = signed_of(a, scaled_sig(a, 23) >> 7);
      OP_FRAC: r.iv = signed_of(a, scaled_sig(a, 16) & 32'h7F);
      OP_AEXP: r.fb = (a & 16'h807F) | {1'b0, 8'((a >> 7) + b), 7'd0};
      default: ;
    endcase
    return r;
  endfunction

  task automatic issue(input logic [2:0] op, input logic [15:0] a, input logic [15:0] b,
                       input logic typed, input res_t want);
    int   gap;
    logic granted;
    gap = fast_mode ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_op        <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    forever begin
      @(negedge clk);
      granted = !busy;
      if (granted) pending_results.push_back(typed ? want : alu_result(op, a, b));
      @(posedge clk);
      if (granted) break;
    end
    sent++;
  endtask

  task automatic issue_predicted(input logic [2:0] op, input logic [15:0] a,
                                 input logic [15:0] b);
    res_t none;
    none = '{fb: '0, iv: '0};
    issue(op, a, b, 1'b0, none);
  endtask

  function automatic logic [15:0] pick_operand();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 9))
      0:       v[14:7] = 8'h00;
      1:       v[14:7] = 8'hFF;
      2, 3:    v[14:7] = 8'($urandom_range(118, 142));
      4:       v[14:7] = 8'($urandom_range(1, 6));
      5:       v[14:7] = 8'($urandom_range(249, 254));
      default: ;
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst_n && ((start && !busy) || out_valid)) quiet_cycles <= 0;
    else                                          quiet_cycles <= quiet_cycles + 1;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: float_bits=%h int_value=%h", out_float_bits, out_int_value);
        errors++;
      end else begin
        want = pending_results.pop_front();
        checked <= checked + 1;
        if (out_float_bits !== want.fb) begin
          $error("float_bits: expected %h, actual %h", want.fb, out_float_bits);
          errors++;
        end
        if (out_int_value !== want.iv) begin
          $error("int_value: expected %h, actual %h", want.iv, out_int_value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles > 3000) begin
      $display("watchdog: no progress for %0d cycles", quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  row_t directed[] = '{
    '{OP_ADD,  16'h3F80, 16'h3F80, 1'b1, 16'h4000, 17'h0},
    '{OP_ADD,  16'h7FC1, 16'h0000, 1'b1, 16'h7FC0, 17'h0},
    '{OP_ADD,  16'h7F80, 16'hFF80, 1'b1, 16'h7FC0, 17'h0},
    '{OP_ADD,  16'h7F7F, 16'h7F7F, 1'b1, 16'h7F80, 17'h0},
    '{OP_ADD,  16'h3F80, 16'hBF80, 1'b1, 16'h0000, 17'h0},
    '{OP_ADD,  16'h8000, 16'h8000, 1'b1, 16'h8000, 17'h0},
    '{OP_ADD,  16'h0001, 16'h807F, 1'b0, 16'h0,    17'h0},
    '{OP_ADD,  16'h3F80, 16'h3B81, 1'b0, 16'h0,    17'h0},
    '{OP_ADD,  16'hFFFF, 16'hFFFF, 1'b1, 16'h7FC0, 17'h0},
    '{OP_MUL,  16'h7F80, 16'h0000, 1'b1, 16'h7FC0, 17'h0},
    '{OP_MUL,  16'h3F80, 16'hC000, 1'b1, 16'hC000, 17'h0},
    '{OP_MUL,  16'h3F81, 16'h3F81, 1'b0, 16'h0,    17'h0},
    '{OP_MUL,  16'h7F7F, 16'h7F7F, 1'b1, 16'h7F80, 17'h0},
    '{OP_MUL,  16'h0080, 16'h0080, 1'b0, 16'h0,    17'h0},
    '{OP_F2I,  16'h3F80, 16'h0000, 1'b1, 16'h0,    17'h00001},
    '{OP_F2I,  16'hBF80, 16'h0000, 1'b1, 16'h0,    17'h1FFFF},
    '{OP_F2I,  16'h477F, 16'hFFFF, 1'b1, 16'h0,    17'h0FF00},
    '{OP_F2I,  16'h0000, 16'h0000, 1'b1, 16'h0,    17'h00000},
    '{OP_F2I,  16'hFFFF, 16'h0000, 1'b1, 16'h0,    17'h00000},
    '{OP_FRAC, 16'h3FC0, 16'h0000, 1'b0, 16'h0,    17'h0},
    '{OP_FRAC, 16'hBFFF, 16'h0000, 1'b0, 16'h0,    17'h0},
    '{OP_AEXP, 16'h3F80, 16'h0001, 1'b1, 16'h4000, 17'h0},
    '{OP_AEXP, 16'hFFFF, 16'hFF01, 1'b1, 16'h807F, 17'h0},
    '{3'd5,    16'hFFFF, 16'hFFFF, 1'b1, 16'h0,    17'h0},
    '{3'd7,    16'h1234, 16'h5678, 1'b1, 16'h0,    17'h0}
  };

  initial begin
    logic [2:0]  op;
    logic [15:0] a;
    logic [15:0] b;
    res_t        want;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      want = '{fb: directed[i].fb, iv: directed[i].iv};
      issue(directed[i].op, directed[i].a, directed[i].b, directed[i].typed, want);
    end
    for (int n = 0; n < 1700; n++) begin
      if (n % 100 == 0) fast_mode = $urandom_range(0, 2) == 0;
      if (n == 850) begin
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      a  = pick_operand();
      b  = pick_operand();
      if (op == OP_ADD && $urandom_range(0, 3) == 0) b = {~a[15], a[14:8], 8'($urandom)};
      issue_predicted(op, a, b);
    end
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d requests over all five operations and unused opcodes;", sent);
    $display("checked %0d results, with and without idle gaps.", checked);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
